FILE: rtl/tdp_pkg.sv
// shared constants and types for the trial division prime test core
// no dependencies; compile first

package tdp_pkg;

    // candidate width in bits (2 to 64)
    localparam int WIDTH = 32;

    // bit counter for one division pass
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] word_t;

    // divider result group back to the sequencer
    typedef struct packed {
        logic  done;
        word_t quot;
        word_t rem;
    } tdp_div_res_t;

endpackage

FILE: rtl/tdp_if.sv
// valid/ready channel interfaces for candidate input and result output
// depends on tdp_pkg

interface tdp_cand_if import tdp_pkg::*;;
    logic  valid;
    logic  ready;
    word_t candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

interface tdp_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);
endinterface

FILE: rtl/tdp_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on tdp_pkg

module tdp_divider import tdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  word_t        dividend,
    input  word_t        divisor,
    output tdp_div_res_t res
);

    word_t            shift_reg, shift_next;
    word_t            rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // one restoring step: bring down the next dividend bit and try the subtract
    always_comb
    begin
        trial      = {rem_reg, shift_reg[WIDTH-1]};
        diff       = trial - {1'b0, divisor};
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CNT_W'(WIDTH - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next   = diff[WIDTH-1:0];
                shift_next = {shift_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next   = trial[WIDTH-1:0];
                shift_next = {shift_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quot = shift_reg;
    assign res.rem  = rem_reg;

endmodule

FILE: rtl/trial_division_prime_test_core.sv
// Trial division prime test. Each candidate on the cand channel yields one is_prime
// result on the res channel; 0 and 1 report not prime. Divisors d = 2, 3, ... are tried
// in turn by a bit-serial divider, one division per divisor, and the search ends at
// the first d that divides the candidate or once d exceeds candidate / d. It tries as many
// divisors as the smallest factor minus one for a composite, or floor(sqrt(candidate)) for
// a prime (up to about 65535 divisors at 32 bits). One candidate is in work at a time; the
// next one is taken as soon as the result is in the output register, even while that
// result waits for a transfer.
// depends on tdp_pkg, tdp_if and tdp_divider

module trial_division_prime_test_core import tdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tdp_cand_if.sink     cand,
    tdp_res_if.source    res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t       state_reg, state_next;
    word_t        n_reg, n_next;
    word_t        d_reg, d_next;
    logic         start_reg, start_next;
    logic         prime_reg, prime_next;
    logic         res_valid_reg, res_valid_next;
    logic         is_prime_reg, is_prime_next;
    logic         cand_xfer;
    tdp_div_res_t div_res;

    assign cand.ready = (state_reg == ST_IDLE);
    assign cand_xfer  = cand.valid && cand.ready;
    assign res.valid    = res_valid_reg;
    assign res.is_prime = is_prime_reg;

    tdp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (n_reg),
        .divisor  (d_reg),
        .res      (div_res)
    );

    // sequencer over trial divisors
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        start_next     = 1'b0;
        prime_next     = prime_reg;
        res_valid_next = res_valid_reg;
        is_prime_next  = is_prime_reg;
        // result transfer frees the output register
        if (res.valid && res.ready)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cand_xfer)
                begin
                    n_next = cand.candidate;
                    d_next = WIDTH'(2);
                    if (cand.candidate[WIDTH-1:1] == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (d_reg > div_res.quot)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (div_res.rem == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        start_next = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    is_prime_next  = prime_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        prime_reg    <= prime_next;
        is_prime_reg <= is_prime_next;
    end

    // divider finishes only while a division is under way
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider done outside a division");

    // trial divisor never drops below two during a division
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (d_reg >= WIDTH'(2)))
        else $error("trial divisor below two");

    // candidates zero and one go straight to a not-prime result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cand_xfer && (cand.candidate[WIDTH-1:1] == '0))
        |=> ((state_reg == ST_FINISH) && !prime_reg))
        else $error("small candidate not reported as not prime");

    // a new result appears only from the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

endmodule
